// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper package
// Shared widths, register indexes, the channel struct between the front end
// and the output stages, and the constant functions that build both tables.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int TABLE_BITS_DEFAULT = 10;
  localparam int FRAC_BITS_DEFAULT  = 16;

  localparam int POS_W    = 17;
  localparam int TURNS_W  = 23;
  localparam int PHASE_W  = 16;
  localparam int CV_W     = 7;
  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 1;
  localparam int ANGLE_W  = 32;
  localparam int PROD_W   = POS_W + TURNS_W;

  localparam int CTRL_DEPTH = 1 << CV_W;

  localparam logic [TURNS_W-1:0] TURNS_RESET = TURNS_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CYCLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET   = CFG_IDX_W'(1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] frac;
  } angle_t;

  // Quarter-wave sine entry, evaluated by a Taylor series in Q2.30.
  function automatic logic [63:0] sine_entry(input int idx, input int tb, input int fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    x    = (HALF_PI_Q30 * 64'(idx)) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int k = 1; k <= 10; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      pos = 64'd0;
    end else begin
      pos = pos - neg;
      if (pos > ONE_Q30) begin
        pos = ONE_Q30;
      end
    end
    return ((pos << fb) + (64'd1 << 29)) >> 30;
  endfunction

  // Cycle count in Q7.16 for a control value: 1 + 4 * value / 127 turns.
  function automatic logic [TURNS_W-1:0] ctrl_turns(input int cv);
    return TURNS_W'(64'd65536 + (64'd262144 * 64'(cv) + 64'd63) / 64'd127);
  endfunction

endpackage

// ===== design/sine_sweep_shaper_core.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper core
// Maps a sweep position to a sine-shaped level (sin + 1) / 2 in Q0.16.
//
//   Channel   Signals                                     Direction
//   item      item_valid, item_stall, action, position,   in
//             control_value
//   result    result_valid, result_stall, level           out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// One item is taken in every cycle unless the item channel is stalled; a level
// passes through the input, multiply, table read and output registers.
// A control change item gives no result and occupies no pipeline slot.
// Reset clears the pipeline at once; there is no clearing pass.
// A stalled result holds the output register; stages behind it keep filling
// empty slots before the item channel is stalled.
// ----------------------------------------------------------------------------
module sine_sweep_shaper_core #(
  parameter int TABLE_BITS = sss_pkg::TABLE_BITS_DEFAULT,
  parameter int FRAC_BITS  = sss_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             action,
  input  logic [sss_pkg::POS_W-1:0]        position,
  input  logic [sss_pkg::CV_W-1:0]         control_value,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [sss_pkg::LEVEL_W-1:0]      level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]        cfg_data
);

  localparam logic [TABLE_BITS:0]  QUARTER = {1'b1, {TABLE_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] ONE     = (FRAC_BITS + 2)'(1) << FRAC_BITS;
  localparam int SUM_W = FRAC_BITS + 18;

  sss_pkg::angle_t          angle;
  logic                     s3_valid;
  logic                     s3_neg;
  logic                     en3;
  logic                     en_out;
  logic [1:0]               quad;
  logic [TABLE_BITS-1:0]    idx;
  logic [TABLE_BITS:0]      addr;
  logic [FRAC_BITS:0]       mag;
  logic [FRAC_BITS+1:0]     u;
  logic [SUM_W-1:0]         sum;
  logic [16:0]              level_wide;
  logic [sss_pkg::LEVEL_W-1:0] level_next;

  assign cfg_ready = 1'b1;
  assign en_out    = !result_valid || !result_stall;
  assign en3       = !s3_valid || en_out;

  sss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .position      (position),
    .control_value (control_value),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .next_ready    (en3),
    .angle         (angle)
  );

  assign quad = angle.frac[31:30];
  assign idx  = angle.frac[29 -: TABLE_BITS];
  assign addr = quad[0] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};

  sss_rom #(
    .TABLE_BITS (TABLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (en3),
    .addr (addr),
    .data (mag)
  );

  assign u          = s3_neg ? (ONE - {1'b0, mag}) : (ONE + {1'b0, mag});
  assign sum        = {u, 16'h0000} + SUM_W'(ONE);
  assign level_wide = sum[FRAC_BITS+17:FRAC_BITS+1];
  assign level_next = level_wide[16] ? '1 : level_wide[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en3) begin
        s3_valid <= angle.valid;
      end
      if (en_out) begin
        result_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_neg <= quad[1];
    end
    if (en_out) begin
      level <= level_next;
    end
  end

endmodule

// ===== design/sss_front.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper front end
// Input register, cycle count and phase registers, and the position by cycle
// count multiply that yields the fractional turn.
// ----------------------------------------------------------------------------
module sss_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             action,
  input  logic [sss_pkg::POS_W-1:0]        position,
  input  logic [sss_pkg::CV_W-1:0]         control_value,
  input  logic                             cfg_valid,
  input  logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             next_ready,
  output sss_pkg::angle_t                  angle
);

  logic [sss_pkg::TURNS_W-1:0] ctrl_rom [sss_pkg::CTRL_DEPTH];

  for (genvar g = 0; g < sss_pkg::CTRL_DEPTH; g++) begin : g_ctrl
    assign ctrl_rom[g] = sss_pkg::ctrl_turns(g);
  end

  logic                          s1_valid;
  logic [sss_pkg::POS_W-1:0]     s1_position;
  logic                          s2_valid;
  logic [sss_pkg::ANGLE_W-1:0]   s2_frac;
  logic [sss_pkg::TURNS_W-1:0]   cycle_turns;
  logic [sss_pkg::PHASE_W-1:0]   phase_offset;
  logic                          s1_en;
  logic                          s2_en;
  logic                          item_take;
  logic [sss_pkg::PROD_W-1:0]    product;
  logic [sss_pkg::ANGLE_W-1:0]   s2_frac_next;

  assign s2_en      = !s2_valid || next_ready;
  assign s1_en      = !s1_valid || s2_en;
  assign item_stall = !s1_en;
  assign item_take  = item_valid && s1_en;

  assign product      = sss_pkg::PROD_W'(s1_position) * sss_pkg::PROD_W'(cycle_turns);
  assign s2_frac_next = product[sss_pkg::ANGLE_W-1:0] + {phase_offset, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      cycle_turns  <= sss_pkg::TURNS_RESET;
      phase_offset <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sss_pkg::CFG_INITIAL_CYCLES: cycle_turns  <= cfg_data;
          sss_pkg::CFG_PHASE_OFFSET:   phase_offset <= cfg_data[sss_pkg::PHASE_W-1:0];
          default: ;
        endcase
      end
      if (item_take && action) begin
        cycle_turns <= ctrl_rom[control_value];
      end
      if (s1_en) begin
        s1_valid <= item_take && !action;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_position <= position;
    end
    if (s2_en) begin
      s2_frac <= s2_frac_next;
    end
  end

  assign angle.valid = s2_valid;
  assign angle.frac  = s2_frac;

endmodule

// ===== design/sss_rom.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper quarter-wave table
// Constant sine table of 2^TABLE_BITS + 1 entries with a registered read.
// ----------------------------------------------------------------------------
module sss_rom #(
  parameter int TABLE_BITS = sss_pkg::TABLE_BITS_DEFAULT,
  parameter int FRAC_BITS  = sss_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TABLE_BITS:0]   addr,
  output logic [FRAC_BITS:0]    data
);

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [FRAC_BITS:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    assign rom[g] = (FRAC_BITS + 1)'(sss_pkg::sine_entry(g, TABLE_BITS, FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

// ===== design/sss_checker.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper port checker
// Watches the ports of the core for handshake and pipeline behaviour.
// ----------------------------------------------------------------------------
module sss_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic                          action,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [sss_pkg::LEVEL_W-1:0]   level
);

  logic shape_take;

  assign shape_take = item_valid && !item_stall && !action;

  // A stalled result stays and holds its level.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(level))
    else $error("stalled result changed");

  // An empty output register means the whole pipeline can move.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("item stalled with empty output");

  // A shape transaction reaches the output when the result channel does not hold it up.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(shape_take, 4) && !$past(result_stall, 1) && !$past(result_stall, 2) &&
    !$past(result_stall, 3) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
    |-> result_valid)
    else $error("shape transaction did not reach the output");

  // The result only drops after a transaction on the result channel.
  a_result_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> !$past(result_stall))
    else $error("result withdrawn without a transaction");

endmodule

bind sine_sweep_shaper_core sss_checker u_checker (.*);

// ===== sim/sss_test_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper test package
// Item action codes shared by the stimulus top and the checker of the sine sweep
// shaper core, and a timing figure used by the stimulus top.
// ----------------------------------------------------------------------------
package sss_test_pkg;

  localparam logic ACT_SHAPE   = 1'b0;
  localparam logic ACT_CONTROL = 1'b1;

  localparam int PIPE_LATENCY = 4;

endpackage

// ===== sim/sine_sweep_shaper_checker.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper checker
// Watches the item, result and register channels of the core, keeps its own
// copy of the cycle count, phase offset and quarter-wave sine table, works
// out the level of every accepted shape transaction and compares each
// accepted result with the oldest level still waiting.
// ----------------------------------------------------------------------------
module sine_sweep_shaper_checker #(
  parameter int TABLE_BITS = sss_pkg::TABLE_BITS_DEFAULT,
  parameter int FRAC_BITS  = sss_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic                          action,
  input  logic [sss_pkg::POS_W-1:0]     position,
  input  logic [sss_pkg::CV_W-1:0]      control_value,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [sss_pkg::LEVEL_W-1:0]   level,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_data,
  output int                            failures,
  output int                            pending
);

  import sss_pkg::*;
  import sss_test_pkg::*;

  localparam logic [63:0] HALF_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30      = 64'd1 << 30;

  logic [63:0]        sine_rom [0:(1 << TABLE_BITS)];
  logic [TURNS_W-1:0] start_turns;
  logic [TURNS_W-1:0] sweep_turns;
  logic [PHASE_W-1:0] phase_q16;
  logic [LEVEL_W-1:0] level_q[$];
  logic [LEVEL_W-1:0] wanted;

  function automatic logic [63:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] up;
    logic [63:0] down;
    x    = (HALF_TURN_Q30 * 64'(i)) >> TABLE_BITS;
    x_sq = (x * x) >> 30;
    term = x;
    up   = x;
    down = 64'd0;
    for (int k = 1; k <= 10; k++) begin
      term = (term * x_sq) >> 30;
      term = term / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        down = down + term;
      end else begin
        up = up + term;
      end
    end
    if (down >= up) begin
      up = 64'd0;
    end else begin
      up = up - down;
      if (up > UNIT_Q30) begin
        up = UNIT_Q30;
      end
    end
    return ((up << FRAC_BITS) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [TURNS_W-1:0] control_turns(input logic [CV_W-1:0] cv);
    logic [63:0] num;
    num = 64'd65536 * (64'd127 + 64'd4 * 64'(cv));
    return TURNS_W'((num + 64'd63) / 64'd127);
  endfunction

  function automatic logic [LEVEL_W-1:0] shape_level(input logic [POS_W-1:0] pos,
                                                     input logic [TURNS_W-1:0] turns,
                                                     input logic [PHASE_W-1:0] offset);
    logic [63:0] prod;
    logic [31:0] angle;
    logic [1:0]  quad;
    logic [63:0] idx;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] lv;
    prod  = 64'(pos) * 64'(turns) + (64'(offset) << 16);
    angle = prod[31:0];
    quad  = angle[31:30];
    idx   = 64'(angle >> (30 - TABLE_BITS)) & ((64'd1 << TABLE_BITS) - 64'd1);
    if (quad[0]) begin
      idx = (64'd1 << TABLE_BITS) - idx;
    end
    mag = sine_rom[idx];
    if (quad[1]) begin
      u = (64'd1 << FRAC_BITS) - mag;
    end else begin
      u = (64'd1 << FRAC_BITS) + mag;
    end
    lv = ((u << 16) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
    if (lv > 64'd65535) begin
      lv = 64'd65535;
    end
    return lv[LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    failures = failures + 1;
    if (failures <= 100) begin
      $display("ERROR %0t: %s", $time, msg);
    end
  endtask

  task automatic queue_level(input logic [LEVEL_W-1:0] lv);
    level_q.insert(level_q.size(), lv);
  endtask

  initial begin
    for (int i = 0; i <= (1 << TABLE_BITS); i++) begin
      sine_rom[i] = quarter_sine(i);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start_turns = TURNS_RESET;
      sweep_turns = TURNS_RESET;
      phase_q16   = '0;
      level_q.delete();
      failures    = 0;
      pending    <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (level_q.size() == 0) begin
          report_mismatch($sformatf("level %0d arrived with none expected", level));
        end else begin
          wanted = level_q.pop_front();
          if (level !== wanted) begin
            report_mismatch($sformatf("level %0d, expected %0d", level, wanted));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_INITIAL_CYCLES) begin
          start_turns = TURNS_W'(cfg_data);
          sweep_turns = start_turns;
        end else if (cfg_index == CFG_PHASE_OFFSET) begin
          phase_q16 = PHASE_W'(cfg_data);
        end
      end
      if (item_valid && !item_stall) begin
        if (action == ACT_CONTROL) begin
          sweep_turns = control_turns(control_value);
        end else begin
          queue_level(shape_level(position, sweep_turns, phase_q16));
        end
      end
      pending <= level_q.size();
    end
  end

endmodule

// ===== sim/sine_sweep_shaper_core_test.sv =====
// ----------------------------------------------------------------------------
// Sine sweep shaper core test
// Drives directed and random shape and control change transactions through
// the core under several register settings, with random idle bursts on both
// channels, a long result hold-off and a full drain mid-run. The checker
// beside the core predicts every level and counts mismatches.
// ----------------------------------------------------------------------------
module sine_sweep_shaper_core_test;

  import sss_pkg::*;
  import sss_test_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 200;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 92;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  logic                 action;
  logic [POS_W-1:0]     position;
  logic [CV_W-1:0]      control_value;
  logic                 result_valid;
  logic                 result_stall;
  logic [LEVEL_W-1:0]   level;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int failures;
  int pending;
  int cycle_count;
  bit send_gaps;
  bit recv_gaps;
  bit long_hold_req;

  sine_sweep_shaper_core dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .position      (position),
    .control_value (control_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .level         (level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sine_sweep_shaper_checker level_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .position      (position),
    .control_value (control_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .level         (level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sine_sweep_shaper_core_test NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [POS_W-1:0] pos,
                           input logic [CV_W-1:0] cv);
    item_valid    <= 1'b1;
    action        <= act;
    position      <= pos;
    control_value <= cv;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic shape(input logic [POS_W-1:0] pos);
    send_item(ACT_SHAPE, pos, CV_W'($urandom));
  endtask

  task automatic control_change(input logic [CV_W-1:0] cv);
    send_item(ACT_CONTROL, POS_W'($urandom), cv);
  endtask

  task automatic wait_drained;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    result_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    action        = ACT_SHAPE;
    position      = '0;
    control_value = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_INITIAL_CYCLES;
    cfg_data      = '0;
    cycle_count   = 0;
    send_gaps     = 1'b1;
    recv_gaps     = 1'b1;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    shape(POS_W'(0));
    shape(POS_W'(65536));
    shape(POS_W'(32768));
    shape(POS_W'(16384));
    shape(POS_W'(49152));
    shape(POS_W'(131071));
    control_change(CV_W'(127));
    shape(POS_W'(12345));
    control_change(CV_W'(0));
    shape(POS_W'(40000));
    wait_drained();

    // A quarter turn of phase with no sweep lands exactly on the sine peak.
    write_reg(CFG_INITIAL_CYCLES, CFG_W'(0));
    write_reg(CFG_PHASE_OFFSET, CFG_W'(16384));
    shape(POS_W'(0));
    shape(POS_W'(65536));
    wait_drained();

    write_reg(CFG_INITIAL_CYCLES, CFG_W'(23'h7FFFFF));
    write_reg(CFG_PHASE_OFFSET, CFG_W'(65535));
    shape(POS_W'(1));
    shape(POS_W'(65536));
    shape(POS_W'(131071));
    wait_drained();

    write_reg(CFG_INITIAL_CYCLES, CFG_W'(6553600));
    write_reg(CFG_PHASE_OFFSET, CFG_W'(0));
    shape(POS_W'(100));
    shape(POS_W'(655));
    shape(POS_W'(32768));
    control_change(CV_W'(64));
    shape(POS_W'(50000));
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_INITIAL_CYCLES, CFG_W'(0));
        1: write_reg(CFG_INITIAL_CYCLES, CFG_W'(6553600));
        2: write_reg(CFG_INITIAL_CYCLES, CFG_W'(23'h7FFFFF));
        3: write_reg(CFG_INITIAL_CYCLES, CFG_W'(65536));
        4: write_reg(CFG_INITIAL_CYCLES, CFG_W'($urandom_range(0, 6553600)));
        default: write_reg(CFG_INITIAL_CYCLES, CFG_W'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PHASE_OFFSET, CFG_W'(0));
        1: write_reg(CFG_PHASE_OFFSET, CFG_W'(65535));
        default: write_reg(CFG_PHASE_OFFSET, CFG_W'($urandom_range(0, 65535)));
      endcase
      if (p == RAND_PHASES - 1) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      if (p == 1) begin
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        if ($urandom_range(0, 99) < 15) begin
          control_change(CV_W'($urandom_range(0, 127)));
        end else begin
          case ($urandom_range(0, 9))
            0: shape(POS_W'($urandom_range(0, 1) * 65536));
            1, 2: shape(POS_W'($urandom_range(65537, 131071)));
            default: shape(POS_W'($urandom_range(0, 65536)));
          endcase
        end
      end
      wait_drained();
    end

    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (failures == 0) begin
      $display("sine_sweep_shaper_core_test OK");
    end else begin
      $display("sine_sweep_shaper_core_test NOT OK");
    end
    $finish;
  end

endmodule
